// ===== src/mstss_pkg.sv =====
`default_nettype none

package mstss_pkg;

    // Command codes carried in the input tuser
    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_READ     = 3'd1,
        CMD_RESET_MS = 3'd2,
        CMD_LOAD_DLY = 3'd3,
        CMD_LOAD_RX  = 3'd4
    } cmd_t;

    // Sensor transfer kinds
    typedef enum logic [2:0] {
        KIND_GYRO_ACC   = 3'd0,
        KIND_GYRO_PTRIG = 3'd1,
        KIND_GYRO_TTRIG = 3'd2,
        KIND_GYRO_BARO  = 3'd3,
        KIND_GYRO_ONLY  = 3'd4
    } kind_t;

    localparam int MsWidth    = 32;
    localparam int SlotWidth  = 4;
    localparam int CntWidth   = 16;
    localparam int SubWidth   = 16;

    localparam logic [9:0]           MsToUs      = 10'd1000;
    localparam logic [SlotWidth-1:0] LastSlot    = 4'd15;
    localparam logic [SlotWidth-1:0] TriggerSlot = 4'd1;
    localparam logic [SlotWidth-1:0] BaroSlot    = 4'd13;

    // Timer subticks per microsecond; zero falls back to one
    localparam int SubticksPerUs = 24;
    localparam int Divisor       = (SubticksPerUs == 0) ? 1 : SubticksPerUs;

    // Exact reciprocal for a 16-bit dividend: q = (x * Recip) >> (16 + DivShift)
    localparam int          DivShift  = $clog2(Divisor);
    localparam int          RecipSh   = SubWidth + DivShift;
    localparam longint      RecipFull = ((64'd1 << RecipSh) + Divisor - 1) / Divisor;
    localparam int          RecipW    = SubWidth + 1;
    localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];

    // Work held between the input register and the result register
    typedef struct packed {
        logic                 is_read;
        logic [MsWidth-1:0]   ms;
        logic [SubWidth-1:0]  sub;
        logic                 xfer_valid;
        kind_t                kind;
        logic                 delay_busy;
        logic                 rx_busy;
    } stage_t;

endpackage

`default_nettype wire

// ===== src/mstss_slot_sched.sv =====
`default_nettype none

module mstss_slot_sched (
    input  wire logic [mstss_pkg::SlotWidth-1:0] slot,
    input  wire logic                            pressure_phase,
    output mstss_pkg::kind_t                     kind,
    output logic [mstss_pkg::SlotWidth-1:0]      slot_next
);

    // Pick the transfer for the current slot
    always_comb begin
        if (!slot[0]) begin
            kind = mstss_pkg::KIND_GYRO_ACC;
        end else if (slot == mstss_pkg::TriggerSlot) begin
            kind = pressure_phase ? mstss_pkg::KIND_GYRO_PTRIG : mstss_pkg::KIND_GYRO_TTRIG;
        end else if (slot == mstss_pkg::BaroSlot) begin
            kind = mstss_pkg::KIND_GYRO_BARO;
        end else begin
            kind = mstss_pkg::KIND_GYRO_ONLY;
        end
    end

    // Advance the slot, wrapping after the last one
    assign slot_next = (slot >= mstss_pkg::LastSlot) ? '0 : slot + 1'b1;

endmodule

`default_nettype wire

// ===== src/mstss_time_conv.sv =====
`default_nettype none

module mstss_time_conv (
    input  wire logic [mstss_pkg::MsWidth-1:0]  ms,
    input  wire logic [mstss_pkg::SubWidth-1:0] sub,
    output logic [mstss_pkg::MsWidth-1:0]       time_us
);

    localparam int ProdW  = mstss_pkg::SubWidth + mstss_pkg::RecipW;
    localparam int MsProdW = mstss_pkg::MsWidth + 10;

    logic [ProdW-1:0]              sub_prod;
    logic [mstss_pkg::SubWidth-1:0] sub_us;
    logic [MsProdW-1:0]            ms_prod;

    // Divide the subtick count by the constant through its reciprocal
    assign sub_prod = ProdW'(sub) * ProdW'(mstss_pkg::Recip);
    assign sub_us   = mstss_pkg::SubWidth'(sub_prod >> mstss_pkg::RecipSh);

    // Scale milliseconds and add; wrap at 32 bits
    assign ms_prod = MsProdW'(ms) * MsProdW'(mstss_pkg::MsToUs);
    assign time_us = ms_prod[mstss_pkg::MsWidth-1:0]
                   + mstss_pkg::MsWidth'(sub_us);

endmodule

`default_nettype wire

// ===== src/ms_tick_sensor_slot_scheduler.sv =====
`default_nettype none

// Millisecond tick unit with a 16-slot sensor scheduler. Each input transfer
// carries one command in s_tuser (tick, read time, reset time, load delay,
// load receive timeout) and yields exactly one result transfer. A tick
// advances the 32-bit millisecond count, counts the delay and receive-timeout
// counters down to zero and, while sensors_ready is set, issues the transfer
// kind of the current slot and steps the slot. A read returns
// ms * 1000 + sub_ms_count / 24 modulo 2^32. One item is taken every clock
// while the input side is not held; the state registers are updated as each
// item is taken at the input. Each item passes an input register and a result
// register, with the time conversion between them, before its result is
// driven on m_tdata. A stalled result holds the input side once both
// registers are full.
module ms_tick_sensor_slot_scheduler (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] sub_ms_count, [16] sensors_ready, [17] pressure_phase,
    // [33:18] load_value, [39:34] zero
    input  wire logic [39:0] s_tdata,
    // [2:0] cmd
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] time_us, [32] transfer_valid, [35:33] transfer_kind,
    // [36] delay_busy, [37] rx_timeout_busy, [39:38] zero
    output logic [39:0]      m_tdata
);

    localparam int MsW   = mstss_pkg::MsWidth;
    localparam int SlotW = mstss_pkg::SlotWidth;
    localparam int CntW  = mstss_pkg::CntWidth;

    mstss_pkg::cmd_t          in_cmd;
    logic [15:0]              in_sub;
    logic                     in_ready;
    logic                     in_pres;
    logic [CntW-1:0]          in_load;

    logic [MsW-1:0]           ms_count_reg,  ms_count_next;
    logic [SlotW-1:0]         slot_reg,      slot_next;
    logic [CntW-1:0]          delay_reg,     delay_next;
    logic [CntW-1:0]          rx_reg,        rx_next;

    logic                     s1_valid_reg;
    mstss_pkg::stage_t        s1_reg, s1_next;
    logic                     out_valid_reg;
    logic [39:0]              out_data_reg, out_data_next;

    mstss_pkg::kind_t         sched_kind;
    logic [SlotW-1:0]         sched_slot_next;
    logic [MsW-1:0]           conv_time;

    logic                     in_xfer;
    logic                     s1_adv;

    assign in_cmd   = mstss_pkg::cmd_t'(s_tuser);
    assign in_sub   = s_tdata[15:0];
    assign in_ready = s_tdata[16];
    assign in_pres  = s_tdata[17];
    assign in_load  = s_tdata[33:18];

    // Pipeline flow: the stage moves on when the result register is empty or its result is taken
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_xfer  = s_tvalid && s_tready;

    mstss_slot_sched u_sched (
        .slot           (slot_reg),
        .pressure_phase (in_pres),
        .kind           (sched_kind),
        .slot_next      (sched_slot_next)
    );

    // Apply the command to the state and capture what the result needs
    always_comb begin
        ms_count_next = ms_count_reg;
        slot_next     = slot_reg;
        delay_next    = delay_reg;
        rx_next       = rx_reg;
        s1_next.is_read    = 1'b0;
        s1_next.ms         = ms_count_reg;
        s1_next.sub        = in_sub;
        s1_next.xfer_valid = 1'b0;
        s1_next.kind       = mstss_pkg::KIND_GYRO_ACC;
        case (in_cmd)
            mstss_pkg::CMD_TICK: begin
                ms_count_next = ms_count_reg + 1'b1;
                delay_next    = (delay_reg != '0) ? delay_reg - 1'b1 : delay_reg;
                rx_next       = (rx_reg != '0) ? rx_reg - 1'b1 : rx_reg;
                if (in_ready) begin
                    s1_next.xfer_valid = 1'b1;
                    s1_next.kind       = sched_kind;
                    slot_next          = sched_slot_next;
                end
            end
            mstss_pkg::CMD_READ:     s1_next.is_read = 1'b1;
            mstss_pkg::CMD_RESET_MS: ms_count_next = '0;
            mstss_pkg::CMD_LOAD_DLY: delay_next = in_load;
            mstss_pkg::CMD_LOAD_RX:  rx_next = in_load;
            default: ;
        endcase
        s1_next.delay_busy = (delay_next != '0);
        s1_next.rx_busy    = (rx_next != '0);
    end

    // Hold state and the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_count_reg <= '0;
            slot_reg     <= '0;
            delay_reg    <= '0;
            rx_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                ms_count_reg <= ms_count_next;
                slot_reg     <= slot_next;
                delay_reg    <= delay_next;
                rx_reg       <= rx_next;
            end
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_reg <= s1_next;
        end
    end

    mstss_time_conv u_conv (
        .ms      (s1_reg.ms),
        .sub     (s1_reg.sub),
        .time_us (conv_time)
    );

    // Pack the result
    always_comb begin
        out_data_next        = '0;
        out_data_next[31:0]  = s1_reg.is_read ? conv_time : '0;
        out_data_next[32]    = s1_reg.xfer_valid;
        out_data_next[35:33] = s1_reg.kind;
        out_data_next[36]    = s1_reg.delay_busy;
        out_data_next[37]    = s1_reg.rx_busy;
    end

    // Hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
